[rtl/queue_wait_cost_estimator_assert.svh]
// Assertion helpers for the queue wait cost estimator.
`ifndef QUEUE_WAIT_COST_ESTIMATOR_ASSERT_SVH
`define QUEUE_WAIT_COST_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QWCE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QWCE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/qwce_pkg.sv]
`default_nettype none
package qwce_pkg;

  localparam int WINDOW_BITS       = 24;
  localparam int FRACTION_BITS     = 8;
  localparam int RHO_FRACTION_BITS = 8;
  localparam int COST_BITS         = 32;
  localparam int FACTOR_BITS       = 16;
  localparam int DIVIDEND_BITS     = 64;

  localparam int COUNT_BITS    = 24;
  localparam int BUSY_BITS     = 24;
  localparam int SQ_BITS       = 40;
  localparam int SQ_SPLIT      = SQ_BITS / 2;
  localparam int RHO_BITS      = 9;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 2;

  localparam int BUSY_SQ_BITS  = 2 * BUSY_BITS;
  localparam int PART_BITS     = COUNT_BITS + SQ_SPLIT;
  localparam int LIMIT_BITS    = BUSY_BITS + RHO_FRACTION_BITS + 1;

  localparam int RECIP_BITS    = 16;
  localparam int NORM_BITS     = RECIP_BITS + 1;
  localparam int CORR_BITS     = NORM_BITS + 1;
  localparam int TBL_IDX_BITS  = 5;
  localparam int DEN_BITS      = WINDOW_BITS + 1;
  localparam int EXP_BITS      = $clog2(DEN_BITS);
  localparam int SHIFT_BITS    = EXP_BITS + 1;
  localparam int HALF_BITS     = DIVIDEND_BITS / 2;
  localparam int HALF_PROD     = HALF_BITS + RECIP_BITS;
  localparam int FULL_PROD     = DIVIDEND_BITS + RECIP_BITS;
  localparam int ADJ_PROD      = COST_BITS + FACTOR_BITS;

  localparam logic [WINDOW_BITS-1:0] WINDOW_RST   = WINDOW_BITS'(65536);
  localparam logic [RHO_BITS-1:0]    MAX_UTIL_RST = RHO_BITS'(230);
  localparam logic [FACTOR_BITS-1:0] ARR_VAR_RST  = FACTOR_BITS'(256);
  localparam logic [FACTOR_BITS-1:0] ADJUST_RST   = FACTOR_BITS'(256);
  localparam logic [LIMIT_BITS-1:0]  LIMIT_RST    = LIMIT_BITS'(65536 * 230);

  localparam logic [FACTOR_BITS-1:0] FIX_ONE = FACTOR_BITS'(1) << FRACTION_BITS;
  localparam logic [CORR_BITS-1:0]   RECIP_TWO = CORR_BITS'(2) << RECIP_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW,
    CFG_MAX_UTIL,
    CFG_ARRIVAL_VAR,
    CFG_ADJUST
  } cfg_idx_e;

  typedef struct packed {
    logic [NORM_BITS-1:0] norm;
    logic [EXP_BITS-1:0]  expo;
  } norm_t;

  // Midpoint reciprocal seeds, round(65536 / (1 + (k + 0.5) / 32)).
  function automatic logic [RECIP_BITS-1:0] recip_lookup(input logic [TBL_IDX_BITS-1:0] idx);
    logic [RECIP_BITS-1:0] r;
    case (idx)
      5'd0:    r = 16'd64528;
      5'd1:    r = 16'd62602;
      5'd2:    r = 16'd60787;
      5'd3:    r = 16'd59075;
      5'd4:    r = 16'd57456;
      5'd5:    r = 16'd55924;
      5'd6:    r = 16'd54471;
      5'd7:    r = 16'd53092;
      5'd8:    r = 16'd51782;
      5'd9:    r = 16'd50534;
      5'd10:   r = 16'd49345;
      5'd11:   r = 16'd48210;
      5'd12:   r = 16'd47127;
      5'd13:   r = 16'd46091;
      5'd14:   r = 16'd45100;
      5'd15:   r = 16'd44151;
      5'd16:   r = 16'd43240;
      5'd17:   r = 16'd42367;
      5'd18:   r = 16'd41528;
      5'd19:   r = 16'd40721;
      5'd20:   r = 16'd39946;
      5'd21:   r = 16'd39199;
      5'd22:   r = 16'd38480;
      5'd23:   r = 16'd37787;
      5'd24:   r = 16'd37118;
      5'd25:   r = 16'd36472;
      5'd26:   r = 16'd35849;
      5'd27:   r = 16'd35246;
      5'd28:   r = 16'd34664;
      5'd29:   r = 16'd34100;
      5'd30:   r = 16'd33554;
      5'd31:   r = 16'd33026;
      default: r = 16'd33026;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/qwce_stream_if.sv]
`default_nettype none
interface qwce_in_if;
  import qwce_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] request_count;
  logic [BUSY_BITS-1:0]  busy_total;
  logic [SQ_BITS-1:0]    service_square_total;

  modport source (output valid, request_count, busy_total, service_square_total,
                  input ready);
  modport sink (input valid, request_count, busy_total, service_square_total,
                output ready);
endinterface

interface qwce_out_if;
  import qwce_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [COST_BITS-1:0] model_cost;
  logic [COST_BITS-1:0] adjusted_cost;
  logic                 result_valid;
  logic                 cost_saturated;

  modport source (output valid, model_cost, adjusted_cost, result_valid, cost_saturated,
                  input ready);
  modport sink (input valid, model_cost, adjusted_cost, result_valid, cost_saturated,
                output ready);
endinterface
`default_nettype wire

[rtl/queue_wait_cost_estimator.sv]
// Queue wait cost estimator, ten-stage pipeline.
// Throughput: one beat per cycle; per-stage valid bits let bubbles close up under
// output backpressure.
// Reset: valid bits clear, config registers return to their documented defaults.
`default_nettype none
`include "queue_wait_cost_estimator_assert.svh"
module queue_wait_cost_estimator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [qwce_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [qwce_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  qwce_in_if.sink                            in_i,
  qwce_out_if.source                         out_o
);
  import qwce_pkg::*;

  localparam int NSTG = 10;

  // configuration
  logic [WINDOW_BITS-1:0] window_q;
  logic [RHO_BITS-1:0]    max_util_q;
  logic [FACTOR_BITS-1:0] arr_var_q;
  logic [FACTOR_BITS-1:0] adjust_q;
  logic [LIMIT_BITS-1:0]  limit_q, limit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= WINDOW_RST;
      max_util_q <= MAX_UTIL_RST;
      arr_var_q  <= ARR_VAR_RST;
      adjust_q   <= ADJUST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WINDOW:      window_q   <= cfg_data_i[WINDOW_BITS-1:0];
        CFG_MAX_UTIL:    max_util_q <= cfg_data_i[RHO_BITS-1:0];
        CFG_ARRIVAL_VAR: arr_var_q  <= cfg_data_i[FACTOR_BITS-1:0];
        CFG_ADJUST:      adjust_q   <= cfg_data_i[FACTOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign limit_d = LIMIT_BITS'(window_q) * LIMIT_BITS'(max_util_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else begin
      limit_q <= limit_d;
    end
  end

  logic [FACTOR_BITS-1:0] ca2m1;
  logic [FACTOR_BITS-1:0] eff_beta;
  assign ca2m1    = (arr_var_q > FIX_ONE) ? arr_var_q - FIX_ONE : '0;
  assign eff_beta = (adjust_q >= FIX_ONE) ? adjust_q : FIX_ONE;

  // stage valid bits and advance enables
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // A: input capture
  logic [COUNT_BITS-1:0] a_count_q;
  logic [BUSY_BITS-1:0]  a_busy_q;
  logic [SQ_BITS-1:0]    a_sq_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_count_q <= in_i.request_count;
      a_busy_q  <= in_i.busy_total;
      a_sq_q    <= in_i.service_square_total;
    end
  end

  // B: window checks, busy square, split count * sqsum
  logic                    b_rej_q;
  logic [BUSY_SQ_BITS-1:0] b_bsq_q;
  logic [PART_BITS-1:0]    b_pl_q, b_ph_q;
  logic [WINDOW_BITS-1:0]  b_diff_q;
  logic                    b_rej_d;
  logic [LIMIT_BITS-1:0]   offered;

  assign offered = {1'b0, a_busy_q, {RHO_FRACTION_BITS{1'b0}}};
  assign b_rej_d = (window_q == '0) || (a_busy_q >= window_q) || (offered >= limit_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_rej_q  <= b_rej_d;
      b_bsq_q  <= BUSY_SQ_BITS'(a_busy_q) * BUSY_SQ_BITS'(a_busy_q);
      b_pl_q   <= PART_BITS'(a_count_q) * PART_BITS'(a_sq_q[SQ_SPLIT-1:0]);
      b_ph_q   <= PART_BITS'(a_count_q) * PART_BITS'(a_sq_q[SQ_BITS-1:SQ_SPLIT]);
      b_diff_q <= window_q - a_busy_q;
    end
  end

  // C: burst term, service term, divisor normalization
  logic                     c_rej_q;
  logic [DIVIDEND_BITS-1:0] c_burst_q, c_service_q;
  norm_t                    c_nrm_q;
  logic [DIVIDEND_BITS-1:0] cs_sum;
  norm_t                    nrm;

  assign cs_sum = DIVIDEND_BITS'(b_pl_q) + {b_ph_q, {SQ_SPLIT{1'b0}}};

  qwce_norm u_norm (
    .den_i ({b_diff_q, 1'b0}),
    .res_o (nrm)
  );

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c_rej_q     <= b_rej_q;
      c_burst_q   <= DIVIDEND_BITS'(b_bsq_q) * DIVIDEND_BITS'(ca2m1);
      c_service_q <= {cs_sum[DIVIDEND_BITS-FRACTION_BITS-1:0], {FRACTION_BITS{1'b0}}};
      c_nrm_q     <= nrm;
    end
  end

  // D: numerator sum, reciprocal seed and first Newton product
  logic                      d_rej_q;
  logic [DIVIDEND_BITS-1:0]  d_num_q;
  logic [RECIP_BITS-1:0]     d_r0_q;
  logic [NORM_BITS-1:0]      d_x_q;
  logic [EXP_BITS-1:0]       d_exp_q;
  logic [RECIP_BITS-1:0]     r0;
  logic [2*RECIP_BITS:0]     np;

  assign r0 = recip_lookup(c_nrm_q.norm[RECIP_BITS-1 -: TBL_IDX_BITS]);
  assign np = (2*RECIP_BITS+1)'(c_nrm_q.norm) * (2*RECIP_BITS+1)'(r0);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      d_rej_q <= c_rej_q;
      d_num_q <= c_burst_q + c_service_q;
      d_r0_q  <= r0;
      d_x_q   <= np[2*RECIP_BITS -: NORM_BITS];
      d_exp_q <= c_nrm_q.expo;
    end
  end

  // E: refined reciprocal
  logic                     e_rej_q;
  logic [DIVIDEND_BITS-1:0] e_num_q;
  logic [RECIP_BITS-1:0]    e_r1_q;
  logic [EXP_BITS-1:0]      e_exp_q;
  logic [CORR_BITS-1:0]     corr;
  logic [RECIP_BITS+CORR_BITS-1:0] rp;

  assign corr = RECIP_TWO - {1'b0, d_x_q};
  assign rp   = (RECIP_BITS+CORR_BITS)'(d_r0_q) * (RECIP_BITS+CORR_BITS)'(corr);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      e_rej_q <= d_rej_q;
      e_num_q <= d_num_q;
      e_r1_q  <= rp[RECIP_BITS +: RECIP_BITS];
      e_exp_q <= d_exp_q;
    end
  end

  // F: numerator times reciprocal, two halves
  logic                 f_rej_q;
  logic [HALF_PROD-1:0] f_plo_q, f_phi_q;
  logic [EXP_BITS-1:0]  f_exp_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      f_rej_q <= e_rej_q;
      f_plo_q <= HALF_PROD'(e_num_q[HALF_BITS-1:0]) * HALF_PROD'(e_r1_q);
      f_phi_q <= HALF_PROD'(e_num_q[DIVIDEND_BITS-1:HALF_BITS]) * HALF_PROD'(e_r1_q);
      f_exp_q <= e_exp_q;
    end
  end

  // G: full product
  logic                 g_rej_q;
  logic [FULL_PROD-1:0] g_full_q;
  logic [EXP_BITS-1:0]  g_exp_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      g_rej_q  <= f_rej_q;
      g_full_q <= FULL_PROD'(f_plo_q) + {f_phi_q, {HALF_BITS{1'b0}}};
      g_exp_q  <= f_exp_q;
    end
  end

  // H: quotient shift and model saturation
  logic                 h_rej_q;
  logic [COST_BITS-1:0] h_model_q;
  logic                 h_sat_q;
  logic [SHIFT_BITS-1:0] qsh;
  logic [FULL_PROD-1:0] quot;
  logic                 qsat;

  assign qsh  = SHIFT_BITS'(RECIP_BITS) + SHIFT_BITS'(g_exp_q);
  assign quot = g_full_q >> qsh;
  assign qsat = |quot[DIVIDEND_BITS-1:COST_BITS];

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      h_rej_q   <= g_rej_q;
      h_model_q <= qsat ? '1 : quot[COST_BITS-1:0];
      h_sat_q   <= qsat;
    end
  end

  // I: adjust factor product
  logic                 i_rej_q;
  logic [COST_BITS-1:0] i_model_q;
  logic                 i_sat_q;
  logic [ADJ_PROD-1:0]  i_ap_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      i_rej_q   <= h_rej_q;
      i_model_q <= h_model_q;
      i_sat_q   <= h_sat_q;
      i_ap_q    <= ADJ_PROD'(h_model_q) * ADJ_PROD'(eff_beta);
    end
  end

  // O: output register; rejected windows read as all zero
  logic [COST_BITS-1:0] o_model_q, o_adj_q;
  logic                 o_res_valid_q, o_sat_q;
  logic                 asat;

  assign asat = |i_ap_q[ADJ_PROD-1:COST_BITS+FRACTION_BITS];

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      o_res_valid_q <= !i_rej_q;
      o_model_q     <= i_rej_q ? '0 : i_model_q;
      o_adj_q       <= i_rej_q ? '0 :
                       (asat ? '1 : i_ap_q[FRACTION_BITS +: COST_BITS]);
      o_sat_q       <= !i_rej_q && (i_sat_q || asat);
    end
  end

  assign out_o.valid          = v_q[NSTG-1];
  assign out_o.model_cost     = o_model_q;
  assign out_o.adjusted_cost  = o_adj_q;
  assign out_o.result_valid   = o_res_valid_q;
  assign out_o.cost_saturated = o_sat_q;

  `QWCE_ASSERT_NEXT(a_limit_track, clk_i, rst_ni, 1'b1,
    limit_q == $past(limit_d), "utilization limit does not follow config")
  `QWCE_ASSERT_NOW(a_ready_when_drained, clk_i, rst_ni, !v_q[NSTG-1],
    in_i.ready, "input stalled while output stage is empty")
  `QWCE_ASSERT_NOW(a_reject_zero, clk_i, rst_ni, out_o.valid && !out_o.result_valid,
    (o_model_q == '0) && (o_adj_q == '0) && !o_sat_q, "rejected window carries cost")

endmodule
`default_nettype wire

[rtl/qwce_norm.sv]
`default_nettype none
module qwce_norm (
  input  logic [qwce_pkg::DEN_BITS-1:0] den_i,
  output qwce_pkg::norm_t               res_o
);
  import qwce_pkg::*;

  logic [EXP_BITS-1:0]            expo;
  logic [DEN_BITS+RECIP_BITS-1:0] shifted;

  // leading one position; highest set bit wins
  always_comb begin
    expo = '0;
    for (int b = 0; b < DEN_BITS; b++) begin
      if (den_i[b]) begin
        expo = EXP_BITS'(b);
      end
    end
  end

  // one shifter covers both directions: leading one lands on bit RECIP_BITS
  assign shifted    = {den_i, {RECIP_BITS{1'b0}}} >> expo;
  assign res_o.norm = shifted[NORM_BITS-1:0];
  assign res_o.expo = expo;

endmodule
`default_nettype wire
